[design/bft_pkg.sv]
`timescale 1ns / 1ps
package bft_pkg;

  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned PTR_W       = $clog2(DEPTH);
  localparam int unsigned LVL_W       = 13;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned PKT_LEN     = 8;
  localparam int unsigned PKT_IDX_W   = $clog2(PKT_LEN);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LVL_W-1:0] LEVEL_FULL    = LVL_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST      = PTR_W'(DEPTH - 1);
  localparam logic [LVL_W-1:0] THRESH_RESET  = LVL_W'(1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_IRQ   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       call_end;
  } cmd_t;

  // Packet pushed on an interrupt event: "IRQ_PKT\n"
  function automatic logic [7:0] irq_byte(input logic [PKT_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h49;
      3'd1:    b = 8'h52;
      3'd2:    b = 8'h51;
      3'd3:    b = 8'h5F;
      3'd4:    b = 8'h50;
      3'd5:    b = 8'h4B;
      3'd6:    b = 8'h54;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

endpackage

[design/bft_front.sv]
`timescale 1ns / 1ps
module bft_front
  import bft_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] op_i,
  input  logic [7:0] data_in_i,
  input  logic       call_end_i,
  output logic       busy_o,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head_q, head_d;
  logic [QIDX_W-1:0] tail_q, tail_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;

  // Classify the raw op code into the command type
  always_comb begin
    cmd_in.op       = op_e'(op_i);
    cmd_in.data     = data_in_i;
    cmd_in.call_end = call_end_i;
  end

  assign busy_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = entry_q[head_q];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push) begin
      tail_d = (tail_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (pop) begin
      head_d = (head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[tail_q] <= cmd_in;
    end
  end

endmodule

[design/bft_back.sv]
`timescale 1ns / 1ps
module bft_back
  import bft_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  input  logic [LVL_W-1:0] thresh_i,
  output logic             done_o,
  output logic [7:0]       data_out_o,
  output logic             ok_o,
  output logic [LVL_W-1:0] fill_level_o,
  output logic             readable_o,
  output logic             writable_o,
  output logic [CNT_W-1:0] read_calls_o,
  output logic [CNT_W-1:0] write_calls_o,
  output logic [CNT_W-1:0] irq_events_o
);

  typedef enum logic [1:0] {
    S_RUN = 2'b01,
    S_IRQ = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0]     level_q, level_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0]     wr_cnt_q, wr_cnt_d;
  logic [CNT_W-1:0]     irq_cnt_q, irq_cnt_d;
  logic [PKT_IDX_W-1:0] pkt_idx_q, pkt_idx_d;
  logic                 done_q, done_d;
  logic                 ok_q, ok_d;
  logic                 rd_sel_q, rd_sel_d;

  logic [7:0]           mem_q [DEPTH];
  logic [7:0]           rdata_q;
  logic                 mem_we;
  logic [7:0]           mem_wdata;
  logic                 mem_re;
  logic                 full;
  logic [PTR_W-1:0]     wr_ptr_inc;
  logic [PTR_W-1:0]     rd_ptr_inc;

  assign full       = (level_q == LEVEL_FULL);
  assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    wr_ptr_d  = wr_ptr_q;
    rd_ptr_d  = rd_ptr_q;
    level_d   = level_q;
    rd_cnt_d  = rd_cnt_q;
    wr_cnt_d  = wr_cnt_q;
    irq_cnt_d = irq_cnt_q;
    pkt_idx_d = pkt_idx_q;
    done_d    = 1'b0;
    ok_d      = 1'b0;
    rd_sel_d  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = cmd_i.data;
    mem_re    = 1'b0;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_RUN: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_WRITE: begin
              done_d = 1'b1;
              if (!full) begin
                mem_we   = 1'b1;
                wr_ptr_d = wr_ptr_inc;
                level_d  = level_q + 1'b1;
                ok_d     = 1'b1;
              end
              if (cmd_i.call_end) begin
                wr_cnt_d = wr_cnt_q + 1'b1;
              end
            end
            OP_READ: begin
              done_d = 1'b1;
              if (level_q != '0) begin
                mem_re   = 1'b1;
                rd_ptr_d = rd_ptr_inc;
                level_d  = level_q - 1'b1;
                ok_d     = 1'b1;
                rd_sel_d = 1'b1;
              end
              if (cmd_i.call_end) begin
                rd_cnt_d = rd_cnt_q + 1'b1;
              end
            end
            OP_IRQ: begin
              irq_cnt_d = irq_cnt_q + 1'b1;
              pkt_idx_d = '0;
              state_d   = S_IRQ;
            end
            default: begin
              wr_ptr_d = '0;
              rd_ptr_d = '0;
              level_d  = '0;
              ok_d     = 1'b1;
              done_d   = 1'b1;
            end
          endcase
        end
      end
      S_IRQ: begin
        mem_wdata = irq_byte(pkt_idx_q);
        if (!full) begin
          mem_we   = 1'b1;
          wr_ptr_d = wr_ptr_inc;
          level_d  = level_q + 1'b1;
        end
        pkt_idx_d = pkt_idx_q + 1'b1;
        // End the packet after its last byte, or drop the rest once the store fills
        if (full || level_d == LEVEL_FULL || pkt_idx_q == PKT_IDX_W'(PKT_LEN - 1)) begin
          done_d  = 1'b1;
          ok_d    = 1'b1;
          state_d = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RUN;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      level_q   <= '0;
      rd_cnt_q  <= '0;
      wr_cnt_q  <= '0;
      irq_cnt_q <= '0;
      pkt_idx_q <= '0;
      done_q    <= 1'b0;
      ok_q      <= 1'b0;
      rd_sel_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      level_q   <= level_d;
      rd_cnt_q  <= rd_cnt_d;
      wr_cnt_q  <= wr_cnt_d;
      irq_cnt_q <= irq_cnt_d;
      pkt_idx_q <= pkt_idx_d;
      done_q    <= done_d;
      ok_q      <= ok_d;
      rd_sel_q  <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  // Level and counters already hold the post-item values in the strobe cycle
  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign data_out_o    = rd_sel_q ? rdata_q : 8'h00;
  assign fill_level_o  = level_q;
  assign readable_o    = (level_q >= thresh_i);
  assign writable_o    = !full;
  assign read_calls_o  = rd_cnt_q;
  assign write_calls_o = wr_cnt_q;
  assign irq_events_o  = irq_cnt_q;

endmodule

[design/byte_fifo_with_threshold_and_stats_top.sv]
`timescale 1ns / 1ps
// Timing: done_o strobes once a command has left the front-end queue and the back end
// has registered its result, for an interrupt event once the packet has ended.
// Throughput: one write, read or clear per cycle while no interrupt event holds the back
// end; an event holds it while it pushes one packet byte per cycle (single write port of
// the store) until the last byte or a full store, with no store write when none fit.
// Reset (rst_ni low, asynchronous): FIFO empty, counters zero, threshold one; the byte
// store itself is not cleared. Results cannot be stalled by the receiver.
module byte_fifo_with_threshold_and_stats_top
  import bft_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Command channel: transaction taken when start_i is high and busy_o is low
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       op_i,
  input  logic [7:0]       data_in_i,
  input  logic             call_end_i,
  // Threshold register write
  input  logic             ready_threshold_we_i,
  input  logic [LVL_W-1:0] ready_threshold_i,
  // Result channel: one transaction per command, valid while done_o is high
  output logic             done_o,
  output logic [7:0]       data_out_o,
  output logic             ok_o,
  output logic [LVL_W-1:0] fill_level_o,
  output logic             readable_o,
  output logic             writable_o,
  output logic [CNT_W-1:0] read_calls_o,
  output logic [CNT_W-1:0] write_calls_o,
  output logic [CNT_W-1:0] irq_events_o
);

  logic [LVL_W-1:0] thresh_q;
  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;

  // Hold the readable threshold; the user must write it only while the block is idle (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (ready_threshold_we_i) begin
      thresh_q <= ready_threshold_i;
    end
  end

  // Front end: decode each command and park it in a two-entry queue, so the caller
  // keeps issuing until the queue fills while the back end works through a packet event
  bft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .op_i        (op_i),
    .data_in_i   (data_in_i),
    .call_end_i  (call_end_i),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: own the byte store, pointers, level and statistics counters,
  // and drive one result per command
  bft_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .thresh_i      (thresh_q),
    .done_o        (done_o),
    .data_out_o    (data_out_o),
    .ok_o          (ok_o),
    .fill_level_o  (fill_level_o),
    .readable_o    (readable_o),
    .writable_o    (writable_o),
    .read_calls_o  (read_calls_o),
    .write_calls_o (write_calls_o),
    .irq_events_o  (irq_events_o)
  );

endmodule

[design/bft_checker.sv]
`timescale 1ns / 1ps
module bft_checker
  import bft_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input logic             done_o,
  input logic [7:0]       data_out_o,
  input logic             ok_o,
  input logic [LVL_W-1:0] fill_level_o,
  input logic             writable_o
);

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> fill_level_o <= LEVEL_FULL)
    else $error("fill level beyond depth");

  a_writable_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> writable_o == (fill_level_o != LEVEL_FULL))
    else $error("writable flag disagrees with fill level");

  a_refused_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> data_out_o == 8'h00)
    else $error("refused transaction returned data");

  a_refused_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ok_o |-> fill_level_o == '0 || fill_level_o == LEVEL_FULL)
    else $error("transaction refused while FIFO neither empty nor full");

  // The command queue only fills on a transaction taken at the previous edge
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy raised without a transaction offered");

endmodule

bind byte_fifo_with_threshold_and_stats_top bft_checker u_bft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .data_out_o   (data_out_o),
  .ok_o         (ok_o),
  .fill_level_o (fill_level_o),
  .writable_o   (writable_o)
);

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
  import bft_pkg::*;

  // Run limits and settle times, in clock cycles
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 24;
  // Sender idle percentage per phase: none, heavy, none, light
  localparam int unsigned GAP_PCT [4]   = '{0, 88, 0, 30};
  localparam int unsigned PHASE_LEN     = 48;
  localparam logic [LVL_W-1:0] THRESH_MAX = '1;
  localparam logic [7:0] IRQ_BYTES [PKT_LEN] =
    '{8'h49, 8'h52, 8'h51, 8'h5F, 8'h50, 8'h4B, 8'h54, 8'h0A};

  typedef enum logic [1:0] {
    JOB_CMD,     // one command transaction
    JOB_THRESH,  // threshold write, only once the block is quiet
    JOB_HOLD     // pause the sender until every result is back
  } job_kind_e;

  typedef struct {
    job_kind_e        kind;
    op_e              op;
    logic [7:0]       data;
    logic             call_end;
    logic [LVL_W-1:0] thresh;
    int unsigned      gap_pct;
  } fifo_job_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             ok;
    logic [LVL_W-1:0] fill_level;
    logic             readable;
    logic             writable;
    logic [CNT_W-1:0] read_calls;
    logic [CNT_W-1:0] write_calls;
    logic [CNT_W-1:0] irq_events;
  } fifo_status_t;

  logic             clk_i                = 1'b0;
  logic             rst_ni               = 1'b0;
  logic             start_i              = 1'b0;
  logic [1:0]       op_i                 = '0;
  logic [7:0]       data_in_i            = '0;
  logic             call_end_i           = 1'b0;
  logic             ready_threshold_we_i = 1'b0;
  logic [LVL_W-1:0] ready_threshold_i    = '0;
  logic             busy_o;
  logic             done_o;
  logic [7:0]       data_out_o;
  logic             ok_o;
  logic [LVL_W-1:0] fill_level_o;
  logic             readable_o;
  logic             writable_o;
  logic [CNT_W-1:0] read_calls_o;
  logic [CNT_W-1:0] write_calls_o;
  logic [CNT_W-1:0] irq_events_o;

  byte_fifo_with_threshold_and_stats_top dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .op_i                 (op_i),
    .data_in_i            (data_in_i),
    .call_end_i           (call_end_i),
    .ready_threshold_we_i (ready_threshold_we_i),
    .ready_threshold_i    (ready_threshold_i),
    .done_o               (done_o),
    .data_out_o           (data_out_o),
    .ok_o                 (ok_o),
    .fill_level_o         (fill_level_o),
    .readable_o           (readable_o),
    .writable_o           (writable_o),
    .read_calls_o         (read_calls_o),
    .write_calls_o        (write_calls_o),
    .irq_events_o         (irq_events_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Pending work for the driver, and the status words still owed by the block
  fifo_job_t    job_backlog_q[$];
  fifo_status_t status_due_q[$];
  int unsigned  mismatches   = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  cycle_count  = 0;

  // Shadow copy of the FIFO: store, pointers, level, threshold and call counters
  logic [7:0]       fifo_image [DEPTH];
  logic [PTR_W-1:0] wr_ptr    = '0;
  logic [PTR_W-1:0] rd_ptr    = '0;
  logic [LVL_W-1:0] held      = '0;
  logic [LVL_W-1:0] threshold = THRESH_RESET;
  logic [CNT_W-1:0] rd_calls  = '0;
  logic [CNT_W-1:0] wr_calls  = '0;
  logic [CNT_W-1:0] irq_count = '0;

  // Stimulus-side bookkeeping: level after all queued commands, and the idle phase
  int          queued_level = 0;
  int unsigned queued_cmds  = 0;

  function automatic logic [PTR_W-1:0] wrap_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic push_shadow(logic [7:0] b);
    if (held == LEVEL_FULL) return 1'b0;
    fifo_image[wr_ptr] = b;
    wr_ptr = wrap_ptr(wr_ptr);
    held++;
    return 1'b1;
  endfunction

  // Advance the shadow FIFO by one command and return the status it must report
  function automatic fifo_status_t apply_fifo_op(op_e op, logic [7:0] din, logic last);
    fifo_status_t s;
    s = '0;
    s.ok = 1'b1;
    case (op)
      OP_WRITE: begin
        s.ok = push_shadow(din);
        if (last) wr_calls++;
      end
      OP_READ: begin
        if (held != '0) begin
          s.data_out = fifo_image[rd_ptr];
          rd_ptr = wrap_ptr(rd_ptr);
          held--;
        end else begin
          s.ok = 1'b0;
        end
        if (last) rd_calls++;
      end
      OP_IRQ: begin
        // Push what fits, drop the rest of the packet
        for (int i = 0; i < PKT_LEN; i++)
          if (!push_shadow(IRQ_BYTES[PKT_IDX_W'(i)])) break;
        irq_count++;
      end
      default: begin
        wr_ptr = '0;
        rd_ptr = '0;
        held   = '0;
      end
    endcase
    s.fill_level  = held;
    s.readable    = (held >= threshold);
    s.writable    = (held < LEVEL_FULL);
    s.read_calls  = rd_calls;
    s.write_calls = wr_calls;
    s.irq_events  = irq_count;
    return s;
  endfunction

  task automatic flag_mismatch(string field, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    $display("%0t ns: %s got %0h, want %0h", $time, field, got, want);
    mismatches++;
  endtask

  // Queue one command; the idle phase rotates with the command count
  task automatic queue_cmd(op_e op, logic [7:0] data, logic call_end);
    fifo_job_t j;
    j.kind     = JOB_CMD;
    j.op       = op;
    j.data     = data;
    j.call_end = call_end;
    j.thresh   = '0;
    j.gap_pct  = GAP_PCT[2'((queued_cmds / PHASE_LEN) % 4)];
    job_backlog_q.push_back(j);
    queued_cmds++;
    case (op)
      OP_WRITE: if (queued_level < DEPTH) queued_level++;
      OP_READ:  if (queued_level > 0) queued_level--;
      OP_IRQ:   queued_level = (queued_level + PKT_LEN > DEPTH) ? DEPTH
                                                                 : queued_level + PKT_LEN;
      default:  queued_level = 0;
    endcase
  endtask

  task automatic queue_job(job_kind_e kind, logic [LVL_W-1:0] thresh);
    fifo_job_t j;
    j = '{kind: kind, op: OP_WRITE, data: '0, call_end: 1'b0, thresh: thresh, gap_pct: 0};
    job_backlog_q.push_back(j);
  endtask

  // Weighted choice of operation
  function automatic op_e pick_op(int unsigned w_wr, int unsigned w_rd, int unsigned w_irq,
                                  int unsigned w_clr);
    int unsigned r;
    r = $urandom_range(w_wr + w_rd + w_irq + w_clr - 1);
    if (r < w_wr) return OP_WRITE;
    if (r < w_wr + w_rd) return OP_READ;
    if (r < w_wr + w_rd + w_irq) return OP_IRQ;
    return OP_CLEAR;
  endfunction

  task automatic queue_random(int unsigned w_wr, int unsigned w_rd, int unsigned w_irq,
                              int unsigned w_clr);
    queue_cmd(pick_op(w_wr, w_rd, w_irq, w_clr), 8'($urandom), 1'($urandom));
    // Now and then hold the sender until the block has drained
    if ($urandom_range(149) == 0) queue_job(JOB_HOLD, '0);
  endtask

  // Driver: take a transaction when start is seen with busy low, then launch the
  // next job. A command stays up (start held) until it is taken.
  always @(posedge clk_i) begin : drive
    logic took;
    logic launch;
    logic thresh_we;
    if (rst_ni) begin
      took = start_i && !busy_o;
      if (took) status_due_q.push_back(apply_fifo_op(op_e'(op_i), data_in_i, call_end_i));
      if (status_due_q.size() == 0 && !start_i) quiet_cycles++;
      else quiet_cycles = 0;
      launch    = 1'b0;
      thresh_we = 1'b0;
      if ((!start_i || took) && job_backlog_q.size() != 0) begin
        case (job_backlog_q[0].kind)
          JOB_CMD: begin
            if ($urandom_range(99) >= job_backlog_q[0].gap_pct) begin
              launch     = 1'b1;
              op_i       <= job_backlog_q[0].op;
              data_in_i  <= job_backlog_q[0].data;
              call_end_i <= job_backlog_q[0].call_end;
              void'(job_backlog_q.pop_front());
            end
          end
          JOB_THRESH: begin
            // Write only once the block has gone quiet
            if (quiet_cycles >= SETTLE_CYCLES) begin
              thresh_we         = 1'b1;
              ready_threshold_i <= job_backlog_q[0].thresh;
              threshold         = job_backlog_q[0].thresh;
              quiet_cycles      = 0;
              void'(job_backlog_q.pop_front());
            end
          end
          default: begin
            if (quiet_cycles >= 1) void'(job_backlog_q.pop_front());
          end
        endcase
      end
      if (!start_i || took) start_i <= launch;
      ready_threshold_we_i <= thresh_we;
    end
  end

  // Monitor: every strobe carries one status; compare it with the oldest one owed
  always @(posedge clk_i) begin : check
    fifo_status_t want;
    if (rst_ni && done_o) begin
      if (status_due_q.size() == 0) begin
        flag_mismatch("unexpected result, fill_level", CNT_W'(fill_level_o), '0);
      end else begin
        want = status_due_q.pop_front();
        if (data_out_o !== want.data_out)
          flag_mismatch("data_out", CNT_W'(data_out_o), CNT_W'(want.data_out));
        if (ok_o !== want.ok) flag_mismatch("ok", CNT_W'(ok_o), CNT_W'(want.ok));
        if (fill_level_o !== want.fill_level)
          flag_mismatch("fill_level", CNT_W'(fill_level_o), CNT_W'(want.fill_level));
        if (readable_o !== want.readable)
          flag_mismatch("readable", CNT_W'(readable_o), CNT_W'(want.readable));
        if (writable_o !== want.writable)
          flag_mismatch("writable", CNT_W'(writable_o), CNT_W'(want.writable));
        if (read_calls_o !== want.read_calls)
          flag_mismatch("read_calls", read_calls_o, want.read_calls);
        if (write_calls_o !== want.write_calls)
          flag_mismatch("write_calls", write_calls_o, want.write_calls);
        if (irq_events_o !== want.irq_events)
          flag_mismatch("irq_events", irq_events_o, want.irq_events);
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // Directed: reset threshold, refused read, byte extremes, packet, clear
    queue_cmd(OP_READ,  8'h00, 1'b1);
    queue_cmd(OP_WRITE, 8'h00, 1'b0);
    queue_cmd(OP_WRITE, 8'hFF, 1'b1);
    queue_cmd(OP_WRITE, 8'h5A, 1'b0);
    queue_cmd(OP_READ,  8'hFF, 1'b0);
    queue_cmd(OP_READ,  8'h00, 1'b1);
    queue_cmd(OP_IRQ,   8'hFF, 1'b1);
    queue_cmd(OP_READ,  8'h00, 1'b0);
    queue_cmd(OP_READ,  8'h00, 1'b0);
    queue_cmd(OP_READ,  8'h00, 1'b1);
    queue_cmd(OP_WRITE, 8'hA5, 1'b1);
    queue_cmd(OP_CLEAR, 8'hFF, 1'b1);
    queue_cmd(OP_READ,  8'h00, 1'b0);
    queue_cmd(OP_IRQ,   8'h00, 1'b0);
    queue_cmd(OP_IRQ,   8'h00, 1'b0);
    queue_cmd(OP_READ,  8'h00, 1'b1);
    queue_cmd(OP_CLEAR, 8'h00, 1'b0);
    queue_cmd(OP_WRITE, 8'h81, 1'b1);
    queue_cmd(OP_READ,  8'h7E, 1'b1);
    // Threshold zero keeps readable set even when empty
    queue_job(JOB_THRESH, '0);
    queue_cmd(OP_READ,  8'h00, 1'b0);
    queue_cmd(OP_WRITE, 8'h7E, 1'b0);
    // Threshold beyond the depth never sets readable
    queue_job(JOB_THRESH, THRESH_MAX);
    queue_cmd(OP_READ,  8'h00, 1'b1);

    // Low fill: every operation mixed, clears included, small thresholds
    queue_job(JOB_THRESH, LVL_W'($urandom_range(2, 12)));
    repeat (60) queue_random(40, 35, 10, 5);
    queue_job(JOB_THRESH, LVL_W'($urandom_range(1, 24)));
    repeat (60) queue_random(40, 35, 10, 5);

    // Fill to the top, mostly with packets; readable flips exactly at full
    queue_job(JOB_THRESH, LEVEL_FULL);
    while (queued_level < DEPTH - 4) queue_random(10, 2, 88, 0);

    // Hover at full: refused writes and partial packets
    repeat (50) queue_random(40, 35, 25, 0);
    queue_job(JOB_THRESH, LEVEL_FULL - 1'b1);
    repeat (50) queue_random(40, 35, 25, 0);

    // Drop everything with a clear, then work the low end with a threshold in range
    queue_job(JOB_THRESH, LVL_W'($urandom_range(1, DEPTH)));
    queue_cmd(OP_CLEAR, 8'h00, 1'b0);
    repeat (20) queue_random(30, 60, 10, 0);

    // Tail at low fill, back at the reset threshold
    queue_job(JOB_HOLD, '0);
    queue_job(JOB_THRESH, THRESH_RESET);
    repeat (40) queue_random(30, 45, 10, 15);

    // Hold reset, then release it on a clock edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Let every job go out and every status come back, then allow for stragglers
    while (job_backlog_q.size() != 0 || start_i || status_due_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && status_due_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
